@@ design/int4_dense_neuron_requant_assert.svh @@
// Assertion macros for the int4 dense neuron requantizer.
// Included by the top level; no other dependencies.
`ifndef INT4_DENSE_NEURON_REQUANT_ASSERT_SVH
`define INT4_DENSE_NEURON_REQUANT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication under synchronous active-low reset
`define IDNR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("idnr assertion failed");
// Next-cycle implication under synchronous active-low reset
`define IDNR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("idnr assertion failed");
`else
`define IDNR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define IDNR_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ design/idnr_pkg.sv @@
// Shared types and constants for the int4 dense neuron requantizer.
// No dependencies; used by idnr_ctrl, idnr_datapath and the top level.
`default_nettype none

package idnr_pkg;

    // Configuration register map (word index = paddr[3:2])
    localparam int unsigned PADDR_W = 4;
    localparam logic [1:0] REG_IN_ZP    = 2'd0;
    localparam logic [1:0] REG_OUT_ZP   = 2'd1;
    localparam logic [1:0] REG_SCALE    = 2'd2;
    localparam logic [1:0] REG_SHIFT    = 2'd3;

    // Reset values
    localparam logic [3:0]  RST_IN_ZP  = 4'd0;
    localparam logic [3:0]  RST_OUT_ZP = 4'd0;
    localparam logic [11:0] RST_SCALE  = 12'd1;
    localparam logic [3:0]  RST_SHIFT  = 4'd0;

    // Saturation bounds
    localparam logic signed [17:0] ACC_MAX = 18'sh1FFFF;
    localparam logic signed [17:0] ACC_MIN = 18'sh20000;
    localparam logic signed [15:0] I16_MAX = 16'sh7FFF;
    localparam logic signed [15:0] I16_MIN = 16'sh8000;
    localparam logic [3:0]         U4_MAX  = 4'd15;

    typedef struct packed {
        logic [3:0]  in_zero_point;
        logic [3:0]  out_offset;
        logic [11:0] requant_scale;
        logic [3:0]  requant_shift;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_SAT,
        ST_MUL,
        ST_ROUND
    } ctrl_state_t;

    // Controller commands to the datapath
    typedef struct packed {
        logic acc_en;    // accumulate the accepted pair
        logic load_sat;  // add bias, saturate to int16, clear accumulator
        logic load_mul;  // register the scaled product
        logic load_out;  // round, shift, offset, clamp into the output register
    } ctrl_cmd_t;

endpackage

`default_nettype wire

@@ design/idnr_ctrl.sv @@
// Controller for the int4 dense neuron requantizer: sequencing and handshakes.
// Depends on idnr_pkg.
`default_nettype none

module idnr_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_last,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output idnr_pkg::ctrl_cmd_t     cmd
);

    idnr_pkg::ctrl_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic slot_free;

    // Output slot can take a new result this cycle
    assign slot_free = !out_valid_reg || m_ready;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= idnr_pkg::ST_ACCUM;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            idnr_pkg::ST_ACCUM: begin
                if (s_valid && s_last) state_next = idnr_pkg::ST_SAT;
            end
            idnr_pkg::ST_SAT:   state_next = idnr_pkg::ST_MUL;
            idnr_pkg::ST_MUL:   state_next = idnr_pkg::ST_ROUND;
            idnr_pkg::ST_ROUND: begin
                if (slot_free) state_next = idnr_pkg::ST_ACCUM;
            end
            default:            state_next = idnr_pkg::ST_ACCUM;
        endcase
    end

    // Outputs
    always_comb begin
        s_ready      = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            idnr_pkg::ST_ACCUM: begin
                s_ready    = 1'b1;
                cmd.acc_en = s_valid;
            end
            idnr_pkg::ST_SAT:   cmd.load_sat = 1'b1;
            idnr_pkg::ST_MUL:   cmd.load_mul = 1'b1;
            idnr_pkg::ST_ROUND: cmd.load_out = slot_free;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Output valid flag
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ design/idnr_datapath.sv @@
// Datapath for the int4 dense neuron requantizer: MAC, bias, scale, round, clamp.
// Depends on idnr_pkg; driven by idnr_ctrl commands.
`default_nettype none

module idnr_datapath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire idnr_pkg::cfg_t      cfg,
    input  wire idnr_pkg::ctrl_cmd_t cmd,
    input  wire logic [3:0]          s_activation,
    input  wire logic signed [3:0]   s_weight,
    input  wire logic signed [15:0]  s_bias,
    output logic [3:0]               m_result
);

    logic signed [17:0] acc_reg, acc_next;
    logic signed [15:0] bias_reg;
    logic signed [15:0] sat_reg, sat_next;
    logic signed [28:0] mul_reg, mul_next;
    logic [3:0]         result_reg, result_next;

    logic signed [4:0]  diff;
    logic signed [8:0]  prod;
    logic signed [18:0] mac_sum;
    logic signed [17:0] mac_sat;
    logic signed [18:0] bias_sum;
    logic [15:0]        half;
    logic signed [29:0] rnd_sum;
    logic signed [29:0] shifted;
    logic signed [30:0] out_sum;

    // MAC: (activation - zero point) * weight, saturating 18-bit accumulate
    assign diff    = $signed({1'b0, s_activation}) - $signed({1'b0, cfg.in_zero_point});
    assign prod    = 9'(diff) * 9'(s_weight);
    assign mac_sum = 19'(acc_reg) + 19'(prod);

    always_comb begin
        if (mac_sum > 19'(idnr_pkg::ACC_MAX)) begin
            mac_sat = idnr_pkg::ACC_MAX;
        end else if (mac_sum < 19'(idnr_pkg::ACC_MIN)) begin
            mac_sat = idnr_pkg::ACC_MIN;
        end else begin
            mac_sat = mac_sum[17:0];
        end
    end

    // Bias add and int16 saturation
    assign bias_sum = 19'(acc_reg) + 19'(bias_reg);

    always_comb begin
        if (bias_sum > 19'(idnr_pkg::I16_MAX)) begin
            sat_next = idnr_pkg::I16_MAX;
        end else if (bias_sum < 19'(idnr_pkg::I16_MIN)) begin
            sat_next = idnr_pkg::I16_MIN;
        end else begin
            sat_next = bias_sum[15:0];
        end
    end

    // Scale: signed 16 x unsigned 12
    assign mul_next = 29'(sat_reg) * 29'($signed({1'b0, cfg.requant_scale}));

    // Round half up, arithmetic shift, add output offset, clamp to 0..15
    assign half    = 16'(16'd1 << cfg.requant_shift) >> 1;
    assign rnd_sum = 30'(mul_reg) + $signed({14'd0, half});
    assign shifted = rnd_sum >>> cfg.requant_shift;
    assign out_sum = 31'(shifted) + $signed({27'd0, cfg.out_offset});

    always_comb begin
        if (out_sum < 31'sd0) begin
            result_next = 4'd0;
        end else if (out_sum > $signed({27'd0, idnr_pkg::U4_MAX})) begin
            result_next = idnr_pkg::U4_MAX;
        end else begin
            result_next = out_sum[3:0];
        end
    end

    // Accumulator: cleared once the finished sum has been taken by the bias stage
    always_comb begin
        acc_next = acc_reg;
        if (cmd.load_sat) begin
            acc_next = '0;
        end else if (cmd.acc_en) begin
            acc_next = mac_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    // Payload stage registers
    always_ff @(posedge aclk) begin
        if (cmd.acc_en) bias_reg <= s_bias;
        if (cmd.load_sat) sat_reg <= sat_next;
        if (cmd.load_mul) mul_reg <= mul_next;
        if (cmd.load_out) result_reg <= result_next;
    end

    assign m_result = result_reg;

endmodule

`default_nettype wire

@@ design/int4_dense_neuron_requant.sv @@
// Int4 dense neuron with requantization, top level: config registers and wiring.
// Depends on idnr_pkg, idnr_ctrl, idnr_datapath and the assertion macro header.
`default_nettype none

// Computes one output neuron of a 4-bit quantized dense layer. Each transfer on
// the s_ channel carries an activation/weight pair; pairs are accumulated at one
// per cycle into a saturating 18-bit accumulator. The transfer with s_last set
// also carries the bias: it steps through the controller states (accumulate,
// bias add with int16 saturation, 16x12 scale multiply, round/shift/offset/clamp)
// before the next pair is taken, and the result then waits in the output
// register for its m_ transfer while new pairs keep flowing. If the previous
// result is still unclaimed when the next one is ready, the round stage holds
// until the output register frees up. The accumulator clears after every last
// pair. Registers (APB, word addresses 0x0..0xC): in_zero_point,
// output offset, requant_scale, requant_shift; write them only while idle.
module int4_dense_neuron_requant (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // APB configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [idnr_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // Input pairs
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [3:0]                   s_activation,
    input  wire logic signed [3:0]            s_weight,
    input  wire logic signed [15:0]           s_bias,
    input  wire logic                         s_last,
    // Results
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [3:0]                        m_result
);

`include "int4_dense_neuron_requant_assert.svh"

    idnr_pkg::cfg_t      cfg_reg;
    idnr_pkg::ctrl_cmd_t cmd;
    logic                cfg_wr;
    logic [1:0]          reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.in_zero_point  <= idnr_pkg::RST_IN_ZP;
            cfg_reg.out_offset     <= idnr_pkg::RST_OUT_ZP;
            cfg_reg.requant_scale  <= idnr_pkg::RST_SCALE;
            cfg_reg.requant_shift  <= idnr_pkg::RST_SHIFT;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                idnr_pkg::REG_IN_ZP:  cfg_reg.in_zero_point  <= pwdata[3:0];
                idnr_pkg::REG_OUT_ZP: cfg_reg.out_offset     <= pwdata[3:0];
                idnr_pkg::REG_SCALE:  cfg_reg.requant_scale  <= pwdata[11:0];
                idnr_pkg::REG_SHIFT:  cfg_reg.requant_shift  <= pwdata[3:0];
                default:              cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (reg_idx)
            idnr_pkg::REG_IN_ZP:  prdata = {28'd0, cfg_reg.in_zero_point};
            idnr_pkg::REG_OUT_ZP: prdata = {28'd0, cfg_reg.out_offset};
            idnr_pkg::REG_SCALE:  prdata = {20'd0, cfg_reg.requant_scale};
            idnr_pkg::REG_SHIFT:  prdata = {28'd0, cfg_reg.requant_shift};
            default:              prdata = '0;
        endcase
    end

    idnr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_last),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    idnr_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .cmd          (cmd),
        .s_activation (s_activation),
        .s_weight     (s_weight),
        .s_bias       (s_bias),
        .m_result     (m_result)
    );

    // A last pair stops intake until its result is finished
    `IDNR_ASSERT_NXT(a_last_blocks, aclk, aresetn, s_valid && s_ready && s_last, !s_ready)
    // Bias stage is always followed by the multiply stage
    `IDNR_ASSERT_NXT(a_sat_then_mul, aclk, aresetn, cmd.load_sat, cmd.load_mul)
    // Loading the output register presents a result next cycle
    `IDNR_ASSERT_NXT(a_load_shows, aclk, aresetn, cmd.load_out, m_valid)
    // Output register is never overwritten while it still holds an unclaimed result
    `IDNR_ASSERT_IMP(a_no_overwrite, aclk, aresetn, cmd.load_out, !m_valid || m_ready)

endmodule

`default_nettype wire

@@ tb/sv/int4_dense_neuron_requant_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for int4_dense_neuron_requant: directed table, then random neurons.
// Depends on idnr_pkg and the int4_dense_neuron_requant top level, which brings in the rest.
module int4_dense_neuron_requant_tb;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 90;
    localparam int NUM_PHASES   = 6;
    localparam int NUM_ROWS     = 28;
    localparam int MAX_REPORTS  = 10;

    // Saturation bounds of the running dot product and the int16 stage
    localparam longint ACC_TOP    = 131071;
    localparam longint ACC_BOTTOM = -131072;
    localparam longint I16_TOP    = 32767;
    localparam longint I16_BOTTOM = -32768;
    localparam longint U4_TOP     = 15;

    typedef enum {ROW_PAIR, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  reg_idx;
        logic [11:0] cfg_val;
        logic [3:0]  act;
        logic [3:0]  wgt;
        logic [15:0] bias;
        bit          last;
        int          reps;
        bit          check;
        logic [3:0]  exp_res;
    } row_t;

    // DUT signals
    logic                         aclk         = 1'b0;
    logic                         aresetn      = 1'b0;
    logic                         psel         = 1'b0;
    logic                         penable      = 1'b0;
    logic                         pwrite       = 1'b0;
    logic [idnr_pkg::PADDR_W-1:0] paddr        = '0;
    logic [31:0]                  pwdata       = '0;
    logic [31:0]                  prdata;
    logic                         pready;
    logic                         s_valid      = 1'b0;
    logic                         s_ready;
    logic [3:0]                   s_activation = '0;
    logic signed [3:0]            s_weight     = '0;
    logic signed [15:0]           s_bias       = '0;
    logic                         s_last       = 1'b0;
    logic                         m_valid;
    logic                         m_ready      = 1'b0;
    logic [3:0]                   m_result;

    // Predictor copy of the registers and the accumulator
    logic [3:0]  zp_in_q  = idnr_pkg::RST_IN_ZP;
    logic [3:0]  zp_out_q = idnr_pkg::RST_OUT_ZP;
    logic [11:0] scale_q  = idnr_pkg::RST_SCALE;
    logic [3:0]  shift_q  = idnr_pkg::RST_SHIFT;
    longint      dot_acc  = 0;

    logic [3:0] neuron_results_due[$];
    int         mismatch_count = 0;
    int         cycle_count    = 0;
    int         send_idle_pct  = 18;
    int         recv_idle_pct  = 81;
    bit         pressure_go    = 1'b0;
    bit         pressure_done  = 1'b0;
    int         hold_left      = 0;
    logic [3:0] want_res;

    row_t directed_rows [NUM_ROWS] = '{
        // reset settings: scale 1, no shift, zero points 0
        '{ROW_PAIR, idnr_pkg::REG_IN_ZP,  12'd0,    4'd0,  4'h0, 16'h0000, 1'b1, 1, 1'b1, 4'd0},
        '{ROW_PAIR, idnr_pkg::REG_IN_ZP,  12'd0,    4'd15, 4'h7, 16'h0000, 1'b1, 1, 1'b1, 4'd15},
        '{ROW_PAIR, idnr_pkg::REG_IN_ZP,  12'd0,    4'd15, 4'h8, 16'h0000, 1'b1, 1, 1'b1, 4'd0},
        '{ROW_PAIR, idnr_pkg::REG_IN_ZP,  12'd0,    4'd0,  4'h0, 16'h7FFF, 1'b1, 1, 1'b1, 4'd15},
        '{ROW_PAIR, idnr_pkg::REG_IN_ZP,  12'd0,    4'd0,  4'h0, 16'h8000, 1'b1, 1, 1'b1, 4'd0},
        // bias on a pair without last is ignored
        '{ROW_PAIR, idnr_pkg::REG_IN_ZP,  12'd0,    4'd3,  4'h2, 16'h8000, 1'b0, 1, 1'b0, 4'd0},
        '{ROW_PAIR, idnr_pkg::REG_IN_ZP,  12'd0,    4'd1,  4'h1, 16'h0002, 1'b1, 1, 1'b1, 4'd9},
        // accumulator must be clear again
        '{ROW_PAIR, idnr_pkg::REG_IN_ZP,  12'd0,    4'd0,  4'h0, 16'h0007, 1'b1, 1, 1'b1, 4'd7},
        '{ROW_CFG,  idnr_pkg::REG_IN_ZP,  12'd15,   4'd0,  4'h0, 16'h0000, 1'b0, 1, 1'b0, 4'd0},
        '{ROW_PAIR, idnr_pkg::REG_IN_ZP,  12'd0,    4'd0,  4'h8, 16'h0000, 1'b1, 1, 1'b0, 4'd0},
        '{ROW_PAIR, idnr_pkg::REG_IN_ZP,  12'd0,    4'd15, 4'h7, 16'hFFFF, 1'b1, 1, 1'b0, 4'd0},
        '{ROW_CFG,  idnr_pkg::REG_SCALE,  12'd4095, 4'd0,  4'h0, 16'h0000, 1'b0, 1, 1'b0, 4'd0},
        '{ROW_CFG,  idnr_pkg::REG_SHIFT,  12'd15,   4'd0,  4'h0, 16'h0000, 1'b0, 1, 1'b0, 4'd0},
        '{ROW_CFG,  idnr_pkg::REG_OUT_ZP, 12'd15,   4'd0,  4'h0, 16'h0000, 1'b0, 1, 1'b0, 4'd0},
        '{ROW_PAIR, idnr_pkg::REG_IN_ZP,  12'd0,    4'd8,  4'h3, 16'h8000, 1'b1, 1, 1'b0, 4'd0},
        '{ROW_PAIR, idnr_pkg::REG_IN_ZP,  12'd0,    4'd0,  4'h1, 16'h7FFF, 1'b1, 1, 1'b0, 4'd0},
        '{ROW_CFG,  idnr_pkg::REG_SCALE,  12'd0,    4'd0,  4'h0, 16'h0000, 1'b0, 1, 1'b0, 4'd0},
        '{ROW_PAIR, idnr_pkg::REG_IN_ZP,  12'd0,    4'd5,  4'hD, 16'h1234, 1'b1, 1, 1'b0, 4'd0},
        // round half up on an odd product, both signs
        '{ROW_CFG,  idnr_pkg::REG_IN_ZP,  12'd0,    4'd0,  4'h0, 16'h0000, 1'b0, 1, 1'b0, 4'd0},
        '{ROW_CFG,  idnr_pkg::REG_SCALE,  12'd3,    4'd0,  4'h0, 16'h0000, 1'b0, 1, 1'b0, 4'd0},
        '{ROW_CFG,  idnr_pkg::REG_SHIFT,  12'd1,    4'd0,  4'h0, 16'h0000, 1'b0, 1, 1'b0, 4'd0},
        '{ROW_CFG,  idnr_pkg::REG_OUT_ZP, 12'd8,    4'd0,  4'h0, 16'h0000, 1'b0, 1, 1'b0, 4'd0},
        '{ROW_PAIR, idnr_pkg::REG_IN_ZP,  12'd0,    4'd1,  4'h1, 16'h0000, 1'b1, 1, 1'b0, 4'd0},
        '{ROW_PAIR, idnr_pkg::REG_IN_ZP,  12'd0,    4'd1,  4'hF, 16'h0000, 1'b1, 1, 1'b0, 4'd0},
        // long stream: 160 pairs climb, then 150 pairs pull below zero
        '{ROW_CFG,  idnr_pkg::REG_SCALE,  12'd1,    4'd0,  4'h0, 16'h0000, 1'b0, 1, 1'b0, 4'd0},
        '{ROW_PAIR, idnr_pkg::REG_IN_ZP,  12'd0,    4'd15, 4'h7, 16'h0000, 1'b0, 160, 1'b0, 4'd0},
        '{ROW_PAIR, idnr_pkg::REG_IN_ZP,  12'd0,    4'd15, 4'h8, 16'h0000, 1'b0, 150, 1'b0, 4'd0},
        '{ROW_PAIR, idnr_pkg::REG_IN_ZP,  12'd0,    4'd0,  4'h0, 16'h0000, 1'b1, 1, 1'b0, 4'd0}
    };

    int4_dense_neuron_requant i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_activation (s_activation),
        .s_weight     (s_weight),
        .s_bias       (s_bias),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_result     (m_result)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // One MAC step of the neuron; returns 1 and the requantized output on last
    function automatic bit requant_neuron_step(input logic [3:0] act,
                                               input logic signed [3:0] wgt,
                                               input logic signed [15:0] bias,
                                               input bit last,
                                               output logic [3:0] res);
        longint sum;
        longint v;
        sum = dot_acc + (longint'(act) - longint'(zp_in_q)) * longint'(wgt);
        sum = clip(sum, ACC_BOTTOM, ACC_TOP);
        res = '0;
        if (!last) begin
            dot_acc = sum;
            return 1'b0;
        end
        v = clip(sum + longint'(bias), I16_BOTTOM, I16_TOP);
        v = v * longint'(scale_q);
        if (shift_q != 0) begin
            v = (v + (longint'(1) <<< (shift_q - 1))) >>> shift_q;
        end
        v = clip(v + longint'(zp_out_q), 0, U4_TOP);
        res = v[3:0];
        dot_acc = 0;
        return 1'b1;
    endfunction

    // Offer one pair, wait for its transfer, record the expected output on a last pair
    task automatic send_pair(input logic [3:0] act, input logic [3:0] wgt,
                             input logic [15:0] bias, input bit last,
                             input bit use_typed, input logic [3:0] typed_res);
        logic [3:0] res;
        bit         has_res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_activation <= act;
        s_weight     <= wgt;
        s_bias       <= bias;
        s_last       <= last;
        do @(posedge aclk); while (!s_ready);
        has_res = requant_neuron_step(act, wgt, bias, last, res);
        if (has_res) neuron_results_due.push_back(use_typed ? typed_res : res);
    endtask

    // Stop offering and wait until the block has nothing left in flight
    task automatic drain_block();
        s_valid <= 1'b0;
        while (neuron_results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // APB write: setup phase, then access until pready, then idle before returning
    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            idnr_pkg::REG_IN_ZP:  zp_in_q  = value[3:0];
            idnr_pkg::REG_OUT_ZP: zp_out_q = value[3:0];
            idnr_pkg::REG_SCALE:  scale_q  = value[11:0];
            idnr_pkg::REG_SHIFT:  shift_q  = value[3:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Register value: low end, high end or anywhere in between
    function automatic logic [31:0] pick_setting(input int unsigned top);
        case ($urandom_range(3))
            0:       return 32'd0;
            1:       return top;
            default: return $urandom_range(top);
        endcase
    endfunction

    // One random neuron: mostly short dot products, rarely 256 to 320 pairs
    task automatic send_random_neuron(output int n_pairs);
        int unsigned draw;
        int          small_bias;
        logic [15:0] bias;
        int          i;
        draw = $urandom_range(99);
        if (draw < 55)      n_pairs = $urandom_range(4, 1);
        else if (draw < 85) n_pairs = $urandom_range(20, 5);
        else if (draw < 98) n_pairs = $urandom_range(80, 21);
        else                n_pairs = $urandom_range(320, 256);
        for (i = 0; i < n_pairs; i++) begin
            if ($urandom_range(99) < 70) begin
                small_bias = int'($urandom_range(128)) - 64;
                bias       = small_bias[15:0];
            end else begin
                bias = 16'($urandom_range(16'hFFFF));
            end
            send_pair(4'($urandom_range(15)), 4'($urandom_range(15)), bias,
                      i == n_pairs - 1, 1'b0, 4'd0);
        end
    endtask

    task automatic note_mismatch(input string what, input logic [3:0] want,
                                 input logic [3:0] got);
        if (mismatch_count < MAX_REPORTS) begin
            $display("ERROR: %s: expected %0d, got %0d at cycle %0d",
                     what, want, got, cycle_count);
        end
        mismatch_count++;
    endtask

    // Result side: check each transfer, then decide m_ready for the next cycle
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (neuron_results_due.size() == 0) begin
                    note_mismatch("result with none expected", 4'd0, m_result);
                end else begin
                    want_res = neuron_results_due.pop_front();
                    if (want_res !== m_result) note_mismatch("result", want_res, m_result);
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if (pressure_go && !pressure_done) begin
                // long hold-off so the output backs up into the input
                pressure_done = 1'b1;
                hold_left    <= HOLD_CYCLES;
                m_ready      <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus
    initial begin
        int   r;
        int   k;
        int   p;
        int   n_pairs;
        int   phase_pairs;
        row_t row;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (r = 0; r < NUM_ROWS; r++) begin
            row = directed_rows[r];
            if (row.kind == ROW_CFG) begin
                drain_block();
                cfg_write(row.reg_idx, {20'd0, row.cfg_val});
            end else begin
                for (k = 0; k < row.reps; k++) begin
                    send_pair(row.act, row.wgt, row.bias, row.last,
                              row.check && (k == row.reps - 1), row.exp_res);
                end
            end
        end

        // random phases, each under its own register setting
        for (p = 0; p < NUM_PHASES; p++) begin
            drain_block();
            if (p == 2) begin
                send_idle_pct = 81;
                recv_idle_pct = 18;
            end else if (p == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                pressure_go   = 1'b1;
            end
            if (p == 1) begin
                cfg_write(idnr_pkg::REG_IN_ZP, 32'd15);
                cfg_write(idnr_pkg::REG_OUT_ZP, 32'd15);
                cfg_write(idnr_pkg::REG_SCALE, 32'd4095);
                cfg_write(idnr_pkg::REG_SHIFT, 32'd15);
            end else begin
                cfg_write(idnr_pkg::REG_IN_ZP, pick_setting(15));
                cfg_write(idnr_pkg::REG_OUT_ZP, pick_setting(15));
                cfg_write(idnr_pkg::REG_SCALE, pick_setting(4095));
                cfg_write(idnr_pkg::REG_SHIFT, pick_setting(15));
            end
            phase_pairs = 0;
            while (phase_pairs < PHASE_ITEMS) begin
                send_random_neuron(n_pairs);
                phase_pairs += n_pairs;
            end
        end

        drain_block();
        if (mismatch_count == 0 && neuron_results_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
